/* design/vpms_pkg.sv */
// ----------------------------------------------------------------------------
// vpms_pkg
// Shared types, codes and constants of the vehicle power mode sequencer.
// ----------------------------------------------------------------------------
package vpms_pkg;

  localparam int CFG_W              = 20;
  localparam int CFG_IDX_W          = 2;
  localparam int TIMER_BITS_DEFAULT = 20;
  localparam int IN_DATA_W          = 24;
  localparam int OUT_DATA_W         = 24;

  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RESET  = CFG_W'(120000);
  localparam logic [CFG_W-1:0] SWITCH_DELAY_RESET  = CFG_W'(1);
  localparam logic [CFG_W-1:0] QUIET_TIME_RESET    = CFG_W'(3000);
  localparam logic [CFG_W-1:0] STANDBY_TIME_RESET  = CFG_W'(6000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT = 2'd0,
    REG_SWITCH_DELAY = 2'd1,
    REG_QUIET_TIME   = 2'd2,
    REG_STANDBY_TIME = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_STANDBY  = 3'd1,
    MODE_SILENT   = 3'd2,
    MODE_RUNNING  = 3'd3,
    MODE_CHARGING = 3'd4,
    MODE_SLEEP    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    BUS_NORMAL   = 2'd0,
    BUS_LISTEN   = 2'd1,
    BUS_DISABLED = 2'd2
  } bus_mode_t;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_RESET   = 3'd1;
  localparam logic [2:0] CMD_SLEEP   = 3'd2;
  localparam logic [2:0] CMD_IO_CTRL = 3'd3;
  localparam logic [2:0] CMD_TESTER  = 3'd4;

  localparam logic [1:0] PLUG_CONNECTED = 2'd1;

  localparam logic [2:0] BATT_NOMINAL     = 3'd0;
  localparam logic [2:0] BATT_NEED_CHARGE = 3'd1;
  localparam logic [2:0] BATT_CHARGED     = 3'd3;

  typedef struct packed {
    logic [CFG_W-1:0] idle_timeout_ms;
    logic [CFG_W-1:0] switch_enable_delay_ms;
    logic [CFG_W-1:0] quiet_time_ms;
    logic [CFG_W-1:0] standby_time_ms;
  } cfg_t;

  typedef struct packed {
    logic       woke_by_watchdog;
    logic       bus_rx_ready;
    logic [2:0] battery_state;
    logic [7:0] pilot_current;
    logic [1:0] plug_state;
    logic       kill_pressed;
    logic [2:0] cmd;
  } in_item_t;

  typedef struct packed {
    logic       reset_request;
    logic [7:0] charger_current;
    logic       charger_enable;
    bus_mode_t  bus_mode;
    logic       debug_led;
    logic       transceiver_sleep;
    logic       controller_sleep;
    logic       switch_enable;
    logic       bms_enable;
    logic       converter_enable;
    logic       battery_enable;
    mode_t      mode;
  } result_t;

endpackage

/* design/vpms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// vpms_cfg_regs
// Timer limit registers, written through the plain write port.
// ----------------------------------------------------------------------------
module vpms_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vpms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpms_pkg::CFG_W-1:0]     cfg_data,
  output vpms_pkg::cfg_t                 cfg
);
  import vpms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_timeout_ms        <= IDLE_TIMEOUT_RESET;
      cfg.switch_enable_delay_ms <= SWITCH_DELAY_RESET;
      cfg.quiet_time_ms          <= QUIET_TIME_RESET;
      cfg.standby_time_ms        <= STANDBY_TIME_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IDLE_TIMEOUT: cfg.idle_timeout_ms        <= cfg_data;
        REG_SWITCH_DELAY: cfg.switch_enable_delay_ms <= cfg_data;
        REG_QUIET_TIME:   cfg.quiet_time_ms          <= cfg_data;
        REG_STANDBY_TIME: cfg.standby_time_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* design/vpms_in_stage.sv */
// ----------------------------------------------------------------------------
// vpms_in_stage
// Input register: captures one tick item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module vpms_in_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [vpms_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            advance,
  output logic                            in_valid,
  output vpms_pkg::in_item_t              in_item
);
  import vpms_pkg::*;

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    end
  end

endmodule

/* design/vpms_core.sv */
// ----------------------------------------------------------------------------
// vpms_core
// Mode state, elapsed timers and latched outputs; one tick is applied per
// taken item: command, pending transition (exit then entry), mode rules.
// ----------------------------------------------------------------------------
module vpms_core #(
  parameter int TIMER_BITS = vpms_pkg::TIMER_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  vpms_pkg::in_item_t in_item,
  input  vpms_pkg::cfg_t     cfg,
  output vpms_pkg::result_t  res
);
  import vpms_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] T_MAX = {TIMER_BITS{1'b1}};

  // latched state
  mode_t                 cur_mode, cur_mode_next;
  mode_t                 pend_mode, pend_mode_next;
  logic                  keep_awake, keep_awake_next;
  logic [TIMER_BITS-1:0] idle_el, idle_el_next;
  logic [TIMER_BITS-1:0] sw_el, sw_el_next;
  logic [TIMER_BITS-1:0] quiet_el, quiet_el_next;
  logic [TIMER_BITS-1:0] stby_el, stby_el_next;
  result_t               outs, outs_next;

  function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] v);
    tick_up = (v == T_MAX) ? v : v + TIMER_BITS'(1);
  endfunction

  function automatic logic expired(input logic [TIMER_BITS-1:0] cnt,
                                   input logic [CFG_W-1:0]      limit);
    expired = CMP_W'(cnt) >= CMP_W'(limit);
  endfunction

  function automatic result_t idle_reset_outs();
    result_t r;
    r               = '0;
    r.mode          = MODE_IDLE;
    r.bus_mode      = BUS_NORMAL;
    r.switch_enable = 1'b1;
    idle_reset_outs = r;
  endfunction

  always_comb begin
    cur_mode_next   = cur_mode;
    pend_mode_next  = pend_mode;
    keep_awake_next = keep_awake;
    idle_el_next    = tick_up(idle_el);
    sw_el_next      = tick_up(sw_el);
    quiet_el_next   = tick_up(quiet_el);
    stby_el_next    = tick_up(stby_el);
    outs_next       = outs;
    outs_next.reset_request = 1'b0;

    if (in_item.cmd == CMD_RESET) begin
      cur_mode_next   = MODE_IDLE;
      pend_mode_next  = MODE_IDLE;
      keep_awake_next = 1'b0;
      idle_el_next    = '0;
      sw_el_next      = '0;
      quiet_el_next   = '0;
      stby_el_next    = '0;
      outs_next       = idle_reset_outs();
      outs_next.reset_request = 1'b1;
    end else begin
      case (in_item.cmd)
        CMD_NONE:  keep_awake_next = 1'b0;
        CMD_SLEEP: pend_mode_next  = MODE_STANDBY;
        default: begin
          if (in_item.cmd inside {CMD_IO_CTRL, CMD_TESTER}) keep_awake_next = 1'b1;
        end
      endcase

      if (pend_mode_next != cur_mode) begin
        // exit actions of the old mode
        case (cur_mode)
          MODE_SILENT: outs_next.debug_led = 1'b0;
          MODE_CHARGING: begin
            outs_next.charger_current = '0;
            outs_next.charger_enable  = 1'b0;
          end
          MODE_SLEEP: outs_next.switch_enable = 1'b1;
          default: ;
        endcase
        cur_mode_next = pend_mode_next;
        // entry actions of the new mode
        case (pend_mode_next)
          MODE_IDLE: begin
            idle_el_next                = '0;
            sw_el_next                  = '0;
            outs_next.battery_enable    = 1'b0;
            outs_next.converter_enable  = 1'b0;
            outs_next.switch_enable     = 1'b1;
            outs_next.controller_sleep  = 1'b0;
            outs_next.bus_mode          = BUS_NORMAL;
            outs_next.transceiver_sleep = 1'b0;
          end
          MODE_STANDBY: begin
            quiet_el_next        = '0;
            stby_el_next         = '0;
            outs_next.bus_mode   = BUS_LISTEN;
            outs_next.bms_enable = 1'b0;
          end
          MODE_SILENT: begin
            outs_next.switch_enable = 1'b1;
            outs_next.debug_led     = 1'b1;
          end
          MODE_SLEEP: begin
            outs_next.switch_enable     = 1'b0;
            outs_next.controller_sleep  = 1'b1;
            outs_next.bms_enable        = 1'b0;
            outs_next.converter_enable  = 1'b0;
            outs_next.bus_mode          = BUS_DISABLED;
            outs_next.transceiver_sleep = 1'b1;
            outs_next.debug_led         = 1'b0;
          end
          default: ;
        endcase
      end

      // rules of the current mode
      case (cur_mode_next)
        MODE_IDLE: begin
          if (expired(sw_el_next, cfg.switch_enable_delay_ms)) begin
            outs_next.battery_enable   = 1'b1;
            outs_next.converter_enable = 1'b1;
            outs_next.bms_enable       = 1'b1;
          end
          if (keep_awake_next) idle_el_next = '0;
          if (expired(idle_el_next, cfg.idle_timeout_ms)) pend_mode_next = MODE_STANDBY;
          if (in_item.plug_state == PLUG_CONNECTED) pend_mode_next = MODE_CHARGING;
          if (in_item.kill_pressed) pend_mode_next = MODE_SLEEP;
        end
        MODE_STANDBY: begin
          if (in_item.bus_rx_ready && expired(quiet_el_next, cfg.quiet_time_ms)) begin
            pend_mode_next = MODE_IDLE;
          end
          if (expired(stby_el_next, cfg.standby_time_ms)) pend_mode_next = MODE_SLEEP;
        end
        MODE_SILENT: begin
          case (in_item.battery_state)
            BATT_NEED_CHARGE: begin
              outs_next.bms_enable       = 1'b1;
              outs_next.converter_enable = 1'b1;
              outs_next.battery_enable   = 1'b1;
              outs_next.bus_mode         = BUS_NORMAL;
            end
            BATT_CHARGED: begin
              outs_next.bus_mode         = BUS_LISTEN;
              outs_next.bms_enable       = 1'b0;
              outs_next.converter_enable = 1'b0;
              outs_next.battery_enable   = 1'b0;
              outs_next.switch_enable    = 1'b0;
            end
            default: ;
          endcase
          // silent wake always ends by requesting idle
          pend_mode_next = MODE_IDLE;
        end
        MODE_RUNNING: pend_mode_next = MODE_IDLE;
        MODE_CHARGING: begin
          if (in_item.plug_state == PLUG_CONNECTED) begin
            outs_next.charger_current = in_item.pilot_current;
            outs_next.charger_enable  = 1'b1;
          end else begin
            pend_mode_next = MODE_IDLE;
          end
        end
        MODE_SLEEP: begin
          pend_mode_next = in_item.woke_by_watchdog ? MODE_SILENT : MODE_IDLE;
        end
        default: ;
      endcase
      outs_next.mode = cur_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode   <= MODE_IDLE;
      pend_mode  <= MODE_IDLE;
      keep_awake <= 1'b0;
      idle_el    <= '0;
      sw_el      <= '0;
      quiet_el   <= '0;
      stby_el    <= '0;
      outs       <= idle_reset_outs();
    end else if (fire) begin
      cur_mode   <= cur_mode_next;
      pend_mode  <= pend_mode_next;
      keep_awake <= keep_awake_next;
      idle_el    <= idle_el_next;
      sw_el      <= sw_el_next;
      quiet_el   <= quiet_el_next;
      stby_el    <= stby_el_next;
      outs       <= outs_next;
    end
  end

  assign res = outs_next;

endmodule

/* design/vpms_out_stage.sv */
// ----------------------------------------------------------------------------
// vpms_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module vpms_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  vpms_pkg::result_t               res,
  output logic                            advance,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [vpms_pkg::OUT_DATA_W-1:0] m_tdata
);
  import vpms_pkg::*;

  result_t out_reg;

  assign advance = !m_tvalid || m_tready;
  assign m_tdata = OUT_DATA_W'(out_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_reg <= res;
    end
  end

endmodule

/* design/vehicle_power_mode_sequencer.sv */
// ----------------------------------------------------------------------------
// vehicle_power_mode_sequencer
// An accepted tick item passes the input register, then the result register.
// Throughput: one tick item per cycle while the sink takes results; the mode
// logic is a single pass between the input register and the result register.
// Reset (rst, synchronous): mode idle with idle entry pin levels, timers
// cleared, timer limits back to their defaults, both registers empty.
// ----------------------------------------------------------------------------
module vehicle_power_mode_sequencer #(
  parameter int TIMER_BITS = vpms_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd[2:0], kill_pressed[3], plug_state[5:4], pilot_current[13:6],
  // battery_state[16:14], bus_rx_ready[17], woke_by_watchdog[18], zero[23:19]
  input  logic [vpms_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mode[2:0], battery_enable[3], converter_enable[4], bms_enable[5],
  // switch_enable[6], controller_sleep[7], transceiver_sleep[8], debug_led[9],
  // bus_mode[11:10], charger_enable[12], charger_current[20:13],
  // reset_request[21], zero[23:22]
  output logic [vpms_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [vpms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpms_pkg::CFG_W-1:0]      cfg_data
);
  import vpms_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  result_t  res;
  logic     in_valid;
  logic     advance;

  vpms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  vpms_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .advance (advance),
    .in_valid(in_valid),
    .in_item (in_item)
  );

  vpms_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (in_valid && advance),
    .in_item(in_item),
    .cfg    (cfg),
    .res    (res)
  );

  vpms_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .res     (res),
    .advance (advance),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
